@@ design/pairwise_radius_overlap_assert.svh @@
// Assertion macros for the pairwise radius overlap block.
`ifndef PAIRWISE_RADIUS_OVERLAP_ASSERT_SVH
`define PAIRWISE_RADIUS_OVERLAP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PRO_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PRO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PRO_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define PRO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/pro_pkg.sv @@
// Shared constants and types of the pairwise radius overlap block.
package pro_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int MAX_DIMS_DEF   = 4;
   localparam int COORD_BITS_DEF = 16;
   localparam int COORD_FIELDS   = 4;
   localparam int THR_W          = 35;
   localparam int DIMS_W         = 3;
   localparam int CSR_ADDR_W     = 1;

   localparam logic [DIMS_W-1:0]     DIMS_RESET    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_THRESHOLD = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_DIMS      = 1'b1;

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_COPY  = 5'b00010,
      ST_CALC  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic copy;
      logic shift;
      logic acc_clr;
      logic acc_add;
   } cell_ctl_type;

endpackage

@@ design/pairwise_radius_overlap.sv @@
// Top level of the pairwise radius overlap block: point loading, row sequencing, output.
//
// Points enter one item per cycle while the block is loading, into a row of MAX_POINTS
// cells, each cell holding one point and one multiplier. The item with req_tlast starts
// the computation: a copy state puts the points into a query chain, then each row steps
// through the calc state (one multiply per dimension in every cell), the drain state
// (which finishes the sum) and the emit state, which waits while the output register is
// full and rsp_tready is low. The next set is taken once the final row has entered the
// output register. There is no clearing pass after reset.
`include "pairwise_radius_overlap_assert.svh"

module pairwise_radius_overlap #(
   parameter int MAX_POINTS = pro_pkg::MAX_POINTS_DEF,
   parameter int MAX_DIMS   = pro_pkg::MAX_DIMS_DEF,
   parameter int COORD_BITS = pro_pkg::COORD_BITS_DEF,
   localparam int IDX_W     = $clog2(MAX_POINTS),
   localparam int REQ_W     = ((pro_pkg::COORD_FIELDS * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_W     = ((IDX_W + MAX_POINTS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [REQ_W-1:0]                 req_tdata,  // coord_0, coord_1, coord_2, coord_3
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_W-1:0]                 rsp_tdata,  // row_index, neighbor_mask
   output logic                             rsp_tlast,
   output logic                             rsp_tuser,  // overflow
   input  logic                             csr_we,
   input  logic [pro_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [pro_pkg::THR_W-1:0]        csr_wdata
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   pro_pkg::state_type                  state_ff, state_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic                                drop_ff, drop_in;
   logic [IDX_W-1:0]                    row_ff, row_in;
   logic [MAX_DIMS-1:0]                 dim_hot_ff, dim_hot_in;
   logic [pro_pkg::THR_W-1:0]           thr_ff, thr_in;
   logic [pro_pkg::DIMS_W-1:0]          dims_ff, dims_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]                    rsp_row_ff, rsp_row_in;
   logic [MAX_POINTS-1:0]               rsp_mask_ff, rsp_mask_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic                                rsp_ovf_ff, rsp_ovf_in;

   logic                                req_acc;
   logic                                store_pt;
   logic                                out_free;
   logic                                emit;
   logic                                row_last;
   logic                                last_dim;
   logic [3:0]                          dims_eff;
   logic [MAX_DIMS-1:0]                 last_sel;
   logic [COORD_BITS-1:0]               qry_coord;
   logic [MAX_POINTS-1:0]               cell_we;
   logic [MAX_POINTS-1:0]               cell_hit;
   logic [MAX_POINTS-1:0]               row_mask;
   logic [MAX_DIMS-1:0][COORD_BITS-1:0] point_in;
   logic [MAX_DIMS-1:0][COORD_BITS-1:0] shd_chain [MAX_POINTS+1];
   pro_pkg::cell_ctl_type               ctl;

   genvar gd, gk;

   generate
      for (gd = 0; gd < MAX_DIMS; gd++) begin : g_pin
         if (gd < pro_pkg::COORD_FIELDS) begin : g_fld
            assign point_in[gd] = req_tdata[gd*COORD_BITS +: COORD_BITS];
         end else begin : g_zero
            assign point_in[gd] = '0;
         end
      end
   endgenerate

   assign req_tready = (state_ff == pro_pkg::ST_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign store_pt   = req_acc && (count_ff != CNT_W'(MAX_POINTS));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = (state_ff == pro_pkg::ST_EMIT) && out_free;
   assign row_last   = (CNT_W'(row_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      if (dims_ff == '0) begin
         dims_eff = 4'd1;
      end else if (4'(dims_ff) > 4'(MAX_DIMS)) begin
         dims_eff = 4'(MAX_DIMS);
      end else begin
         dims_eff = 4'(dims_ff);
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         last_sel[d] = (4'(d + 1) == dims_eff);
      end
      last_dim = |(dim_hot_ff & last_sel);

      qry_coord = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         qry_coord = qry_coord | (shd_chain[0][d] & {COORD_BITS{dim_hot_ff[d]}});
      end

      ctl.copy    = (state_ff == pro_pkg::ST_COPY);
      ctl.shift   = emit;
      ctl.acc_clr = (state_ff == pro_pkg::ST_CALC) && dim_hot_ff[0];
      ctl.acc_add = ((state_ff == pro_pkg::ST_CALC) && !dim_hot_ff[0])
                    || (state_ff == pro_pkg::ST_DRAIN);

      for (int k = 0; k < MAX_POINTS; k++) begin
         row_mask[k] = cell_hit[k] && (CNT_W'(k) < count_ff) && (IDX_W'(k) != row_ff);
      end
   end

   generate
      for (gk = 0; gk < MAX_POINTS; gk++) begin : g_cell
         assign cell_we[gk] = store_pt && (count_ff == CNT_W'(gk));
         pro_cell #(
            .MAX_DIMS   (MAX_DIMS),
            .COORD_BITS (COORD_BITS)
         ) u_cell (
            .clock     (clock),
            .point_we  (cell_we[gk]),
            .point_in  (point_in),
            .ctl       (ctl),
            .dim_hot   (dim_hot_ff),
            .qry_coord (qry_coord),
            .threshold (thr_ff),
            .shd_in    (shd_chain[gk+1]),
            .shd_out   (shd_chain[gk]),
            .hit       (cell_hit[gk])
         );
      end
   endgenerate

   assign shd_chain[MAX_POINTS] = '0;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      drop_in    = drop_ff;
      row_in     = row_ff;
      dim_hot_in = (state_ff == pro_pkg::ST_CALC) ? (dim_hot_ff << 1) : MAX_DIMS'(1);
      thr_in     = thr_ff;
      dims_in    = dims_ff;

      if (csr_we && (csr_addr == pro_pkg::REG_THRESHOLD)) begin
         thr_in = csr_wdata;
      end
      if (csr_we && (csr_addr == pro_pkg::REG_DIMS)) begin
         dims_in = csr_wdata[pro_pkg::DIMS_W-1:0];
      end

      case (state_ff)
         pro_pkg::ST_LOAD: begin
            if (store_pt) begin
               count_in = count_ff + CNT_W'(1);
            end else if (req_acc) begin
               drop_in = 1'b1;
            end
            if (req_acc && req_tlast) begin
               state_in = pro_pkg::ST_COPY;
            end
         end
         pro_pkg::ST_COPY: begin
            row_in   = '0;
            state_in = pro_pkg::ST_CALC;
         end
         pro_pkg::ST_CALC: begin
            if (last_dim) begin
               state_in = pro_pkg::ST_DRAIN;
            end
         end
         pro_pkg::ST_DRAIN: begin
            state_in = pro_pkg::ST_EMIT;
         end
         pro_pkg::ST_EMIT: begin
            if (out_free) begin
               if (row_last) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  row_in   = '0;
                  state_in = pro_pkg::ST_LOAD;
               end else begin
                  row_in   = row_ff + IDX_W'(1);
                  state_in = pro_pkg::ST_CALC;
               end
            end
         end
         default: begin
            state_in = pro_pkg::ST_LOAD;
         end
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_row_in   = emit ? row_ff   : rsp_row_ff;
      rsp_mask_in  = emit ? row_mask : rsp_mask_ff;
      rsp_last_in  = emit ? row_last : rsp_last_ff;
      rsp_ovf_in   = emit ? drop_ff  : rsp_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pro_pkg::ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         row_ff       <= '0;
         dim_hot_ff   <= MAX_DIMS'(1);
         thr_ff       <= '0;
         dims_ff      <= pro_pkg::DIMS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         row_ff       <= row_in;
         dim_hot_ff   <= dim_hot_in;
         thr_ff       <= thr_in;
         dims_ff      <= dims_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff  <= rsp_row_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_mask_ff, rsp_row_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   `PRO_ASSERT_NEXT(a_drop_on_full, clock, reset,
      req_acc && (count_ff == CNT_W'(MAX_POINTS)), drop_ff, "full store did not flag overflow")
   `PRO_ASSERT_NEXT(a_set_done, clock, reset, emit && row_last,
      (count_ff == '0) && !drop_ff && (state_ff == pro_pkg::ST_LOAD), "set not cleared after last row")
   `PRO_ASSERT_NOW(a_self_clear, clock, reset, rsp_valid_ff,
      !rsp_mask_ff[rsp_row_ff], "self bit set in neighbor row")
   `PRO_ASSERT_NOW(a_dim_onehot, clock, reset, state_ff == pro_pkg::ST_CALC,
      $onehot(dim_hot_ff) && ((dim_hot_ff & ~last_sel) != '0 || last_dim), "dimension step lost")

endmodule

@@ design/pro_cell.sv @@
// One point cell: stored point, travelling query copy and squared distance accumulator.
module pro_cell #(
   parameter int MAX_DIMS   = pro_pkg::MAX_DIMS_DEF,
   parameter int COORD_BITS = pro_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 point_we,
   input  logic [MAX_DIMS-1:0][COORD_BITS-1:0]  point_in,
   input  pro_pkg::cell_ctl_type                ctl,
   input  logic [MAX_DIMS-1:0]                  dim_hot,
   input  logic [COORD_BITS-1:0]                qry_coord,
   input  logic [pro_pkg::THR_W-1:0]            threshold,
   input  logic [MAX_DIMS-1:0][COORD_BITS-1:0]  shd_in,
   output logic [MAX_DIMS-1:0][COORD_BITS-1:0]  shd_out,
   output logic                                 hit
);

   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int ACC_W = SQ_W + 3;
   localparam int CMP_W = (ACC_W > pro_pkg::THR_W) ? ACC_W : pro_pkg::THR_W;

   logic [MAX_DIMS-1:0][COORD_BITS-1:0] pnt_ff, pnt_in;
   logic [MAX_DIMS-1:0][COORD_BITS-1:0] shd_ff, shd_in_nxt;
   logic [SQ_W-1:0]                     sq_ff, sq_in;
   logic [ACC_W-1:0]                    acc_ff, acc_in;
   logic [COORD_BITS-1:0]               own;
   logic [COORD_BITS:0]                 diff;
   logic [COORD_BITS:0]                 neg;
   logic [COORD_BITS-1:0]               mag;

   always_comb begin
      own = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         own = own | (pnt_ff[d] & {COORD_BITS{dim_hot[d]}});
      end
      diff = {own[COORD_BITS-1], own} - {qry_coord[COORD_BITS-1], qry_coord};
      neg  = -diff;
      mag  = diff[COORD_BITS] ? neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
      sq_in = {{COORD_BITS{1'b0}}, mag} * {{COORD_BITS{1'b0}}, mag};

      pnt_in = point_we ? point_in : pnt_ff;

      if (ctl.copy) begin
         shd_in_nxt = pnt_ff;
      end else if (ctl.shift) begin
         shd_in_nxt = shd_in;
      end else begin
         shd_in_nxt = shd_ff;
      end

      if (ctl.acc_clr) begin
         acc_in = '0;
      end else if (ctl.acc_add) begin
         acc_in = acc_ff + ACC_W'(sq_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      pnt_ff <= pnt_in;
      shd_ff <= shd_in_nxt;
      sq_ff  <= sq_in;
      acc_ff <= acc_in;
   end

   assign shd_out = shd_ff;
   assign hit     = CMP_W'(acc_ff) <= CMP_W'(threshold);

endmodule

@@ tb/tb.sv @@
// Testbench for pairwise_radius_overlap: point sets in, neighbor rows checked against a predictor.
`timescale 1ns / 100ps

module tb;
   import pro_pkg::*;

   localparam int MAX_PTS = MAX_POINTS_DEF;
   localparam int NDIMS   = MAX_DIMS_DEF;
   localparam int CBITS   = COORD_BITS_DEF;
   localparam int REQ_W   = ((COORD_FIELDS * CBITS + 7) / 8) * 8;
   localparam int RSP_W   = (($clog2(MAX_PTS) + MAX_PTS + 7) / 8) * 8;
   localparam logic [THR_W-1:0] THR_MAX = '1;

   typedef struct packed {
      logic             last;
      logic [REQ_W-1:0] coords;
   } point_item_t;

   typedef struct {
      logic [5:0]  row_idx;
      logic [63:0] nbr_mask;
      logic        ovf;
      logic        final_row;
   } nbr_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;  // coord_0, coord_1, coord_2, coord_3
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;       // row_index, neighbor_mask
   logic                  rsp_tlast;
   logic                  rsp_tuser;       // overflow
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [THR_W-1:0]      csr_wdata = '0;

   pairwise_radius_overlap dut (.*);

   point_item_t       pending_points[$];
   nbr_row_t          rows_due[$];
   logic signed [CBITS-1:0] pt_store [MAX_PTS][NDIMS];
   int                pts_held = 0;
   bit                pts_dropped = 1'b0;
   logic [THR_W-1:0]  thr_reg = '0;
   logic [DIMS_W-1:0] dims_reg = DIMS_RESET;

   int items_queued = 0;
   int items_taken  = 0;
   int mismatches   = 0;
   bit req_busy = 1'b0, req_taken = 1'b0, req_calm = 1'b0;
   bit rsp_taken = 1'b0, rsp_calm = 1'b0;
   int req_gap = 0, rsp_stall = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // Store one point; on the last point of a set, produce every neighbor row.
   function automatic void take_point(logic [REQ_W-1:0] coords, logic last);
      int          eff_dims;
      longint      diff;
      longint unsigned dsq;
      nbr_row_t    row;
      if (pts_held < MAX_PTS) begin
         for (int d = 0; d < NDIMS; d++) pt_store[pts_held][d] = coords[CBITS*d +: CBITS];
         pts_held++;
      end else begin
         pts_dropped = 1'b1;
      end
      if (!last) return;
      eff_dims = (dims_reg == 0) ? 1 : ((dims_reg > NDIMS) ? NDIMS : int'(dims_reg));
      for (int i = 0; i < pts_held; i++) begin
         row.row_idx   = 6'(i);
         row.nbr_mask  = '0;
         row.ovf       = pts_dropped;
         row.final_row = (i + 1 == pts_held);
         for (int j = 0; j < pts_held; j++) begin
            dsq = 0;
            for (int d = 0; d < eff_dims; d++) begin
               diff = longint'(pt_store[i][d]) - longint'(pt_store[j][d]);
               dsq += diff * diff;
            end
            if (j != i && dsq <= thr_reg) row.nbr_mask[j] = 1'b1;
         end
         rows_due.push_back(row);
      end
      pts_held = 0;
      pts_dropped = 1'b0;
   endfunction

   always @(posedge clock) begin
      nbr_row_t want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            take_point(req_tdata, req_tlast);
            items_taken++;
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1'b1;
            if (rows_due.size() == 0) begin
               report_mismatch($sformatf("unexpected row %0d", rsp_tdata[5:0]));
            end else begin
               want = rows_due.pop_front();
               if (rsp_tdata[5:0] !== want.row_idx)
                  report_mismatch($sformatf("row_index got %0d want %0d",
                                            rsp_tdata[5:0], want.row_idx));
               if (rsp_tdata[69:6] !== want.nbr_mask)
                  report_mismatch($sformatf("row %0d neighbor_mask got %h want %h",
                                            want.row_idx, rsp_tdata[69:6], want.nbr_mask));
               if (rsp_tuser !== want.ovf)
                  report_mismatch($sformatf("row %0d overflow got %b want %b",
                                            want.row_idx, rsp_tuser, want.ovf));
               if (rsp_tlast !== want.final_row)
                  report_mismatch($sformatf("row %0d last_row got %b want %b",
                                            want.row_idx, rsp_tlast, want.final_row));
            end
         end
      end
   end

   // Point driver: hold each item until taken, then idle for a drawn gap.
   always @(negedge clock) begin
      point_item_t cur;
      if (!reset) begin
         if (req_busy && req_taken) req_busy = 1'b0;
         req_taken = 1'b0;
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_points.size() > 0) begin
               cur = pending_points.pop_front();
               req_tdata <= cur.coords;
               req_tlast <= cur.last;
               req_busy = 1'b1;
               req_gap = draw_wait(req_calm);
            end
         end
      end
      req_tvalid <= req_busy;
   end

   // Row receiver: stall for a drawn number of cycles after each item.
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         rsp_stall = draw_wait(rsp_calm);
      end
      if (!reset && rsp_stall == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         if (rsp_stall > 0) rsp_stall--;
         rsp_tready <= 1'b0;
      end
   end

   function automatic int clamp_coord(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic void queue_point(int c0, int c1, int c2, int c3, bit last);
      point_item_t it;
      it.coords = {16'(c3), 16'(c2), 16'(c1), 16'(c0)};
      it.last = last;
      pending_points.push_back(it);
      items_queued++;
   endfunction

   task automatic wait_idle();
      do @(negedge clock); while (items_taken != items_queued || rows_due.size() != 0);
      repeat (24) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [THR_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_THRESHOLD) thr_reg = val;
      else dims_reg = val[DIMS_W-1:0];
   endtask

   initial begin
      int  set_size, spread, items_random;
      int  center [NDIMS];
      int  c [NDIMS];
      bit  noisy;
      logic [THR_W-1:0] thr;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset settings: single point, then duplicates in the two dimensions in use at zero threshold
      queue_point(5, -7, 0, 0, 1'b1);
      queue_point(0, 0, 0, 0, 1'b0);
      queue_point(0, 0, 5, 5, 1'b0);
      queue_point(1, 0, 0, 0, 1'b1);
      wait_idle();
      write_reg(REG_THRESHOLD, THR_MAX);
      write_reg(REG_DIMS, THR_W'(4));
      rsp_calm = 1'b1;
      queue_point(-32768, -32768, -32768, -32768, 1'b0);
      queue_point(32767, 32767, 32767, 32767, 1'b0);
      queue_point(0, 0, 0, 0, 1'b0);
      queue_point(-32768, 32767, -32768, 32767, 1'b1);
      wait_idle();
      // zero dims acts as one; distance exactly at the threshold overlaps
      write_reg(REG_THRESHOLD, THR_W'(9));
      write_reg(REG_DIMS, THR_W'(0));
      req_calm = 1'b1;
      queue_point(0, 100, 0, 0, 1'b0);
      queue_point(3, -100, 0, 0, 1'b0);
      queue_point(-3, 0, 0, 0, 1'b1);
      wait_idle();
      // dims above the maximum act as four
      write_reg(REG_THRESHOLD, THR_W'(8));
      write_reg(REG_DIMS, THR_W'(7));
      queue_point(0, 0, 0, 0, 1'b0);
      queue_point(1, 1, 1, 1, 1'b0);
      queue_point(0, 0, 0, 3, 1'b1);
      wait_idle();

      items_random = 0;
      for (int s = 0; items_random < 370; s++) begin
         set_size = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
         if (s == 3) set_size = MAX_PTS;
         if (s == 9) set_size = MAX_PTS + $urandom_range(1, 4);
         spread = 1 << $urandom_range(0, 14);
         noisy = ($urandom_range(0, 4) == 0);
         if (s == 0 || $urandom_range(0, 4) < 3) begin
            wait_idle();
            case ($urandom_range(0, 9))
               0: thr = '0;
               1: thr = THR_MAX;
               2: thr = THR_W'({$urandom, $urandom});
               default: thr = THR_W'(longint'(spread) * spread * $urandom_range(1, 8) / 2);
            endcase
            write_reg(REG_THRESHOLD, thr);
            if ($urandom_range(0, 1) == 0) write_reg(REG_DIMS, THR_W'($urandom_range(0, 7)));
            else write_reg(REG_DIMS, THR_W'({$urandom, $urandom}));
         end
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         for (int d = 0; d < NDIMS; d++) center[d] = $urandom_range(0, 65535) - 32768;
         for (int p = 0; p < set_size; p++) begin
            for (int d = 0; d < NDIMS; d++) begin
               if (noisy) c[d] = $urandom_range(0, 65535) - 32768;
               else c[d] = clamp_coord(center[d] + int'($urandom_range(0, 2 * spread)) - spread);
            end
            queue_point(c[0], c[1], c[2], c[3], p == set_size - 1);
         end
         items_random += set_size;
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (rows_due.size() != 0)
         report_mismatch($sformatf("%0d rows never arrived", rows_due.size()));
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/pro_pkg.sv
design/pro_cell.sv
design/pairwise_radius_overlap.sv
tb/tb.sv
